/* rtl/rgbpwe_pkg.sv */
package rgbpwe_pkg;

  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned TickW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned BitCntW = $clog2(BitsPerPixel);
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(BitsPerPixel - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_RESET_LOW = 3'd4
  } cfg_idx_e;

  localparam logic [TickW-1:0] OneHighRst  = 16'd24;
  localparam logic [TickW-1:0] OneLowRst   = 16'd8;
  localparam logic [TickW-1:0] ZeroHighRst = 16'd10;
  localparam logic [TickW-1:0] ZeroLowRst  = 16'd16;
  localparam logic [TickW-1:0] ResetLowRst = 16'd14400;

  typedef struct packed {
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
    logic [TickW-1:0] reset_low;
  } cfg_t;

  typedef struct packed {
    logic [BitsPerPixel-1:0] bits;
    logic                    frame_start;
  } word_t;

  typedef struct packed {
    logic             pin_level;
    logic [TickW-1:0] duration;
    logic             last;
  } seg_t;

  // A duration of zero would be meaningless on the line, so it counts as one tick.
  function automatic logic [TickW-1:0] min_one(input logic [TickW-1:0] v);
    logic [TickW-1:0] r;
    r = (v == '0) ? TickW'(1) : v;
    return r;
  endfunction

endpackage

/* rtl/rgbpwe_if.sv */
interface rgbpwe_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;

  modport source (output valid, output red, output green, output blue,
                  output frame_start, input ready);
  modport sink (input valid, input red, input green, input blue,
                input frame_start, output ready);
endinterface

interface rgbpwe_seg_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [15:0] duration;
  logic        last;

  modport source (output valid, output pin_level, output duration, output last,
                  input ready);
  modport sink (input valid, input pin_level, input duration, input last,
                output ready);
endinterface

/* rtl/rgbpwe_front.sv */
module rgbpwe_front
  import rgbpwe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  rgbpwe_pixel_if.sink pix_i,
  output logic         push_o,
  output word_t        push_word_o,
  input  logic         push_ready_i
);

  logic  valid_q, valid_d;
  word_t word_q, word_d;
  logic  accept;

  assign pix_i.ready = !valid_q || push_ready_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign push_o      = valid_q;
  assign push_word_o = word_q;

  // The wire order is green, red, blue, each byte most significant bit first.
  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    if (push_o && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d          = 1'b1;
      word_d.bits      = {pix_i.green, pix_i.red, pix_i.blue};
      word_d.frame_start = pix_i.frame_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

/* rtl/rgbpwe_queue.sv */
module rgbpwe_queue
  import rgbpwe_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  word_t push_word_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output word_t pop_word_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  word_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != CntFull;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_word_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("queue fill count exceeds its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count missed a push");

endmodule

/* rtl/rgbpwe_back.sv */
module rgbpwe_back
  import rgbpwe_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  input  logic           q_valid_i,
  input  word_t          q_word_i,
  output logic           q_pop_o,
  rgbpwe_seg_if.source   seg_o
);

  logic                    busy_q, busy_d;
  logic                    rst_pend_q, rst_pend_d;
  logic                    phase_q, phase_d;
  logic [BitCntW-1:0]      cnt_q, cnt_d;
  logic [BitsPerPixel-1:0] bits_q, bits_d;
  logic                    out_valid_q, out_valid_d;
  seg_t                    seg_q, seg_d, seg_next;
  logic                    out_free, emit, fin_emit, load, cur_bit;

  assign out_free = !out_valid_q || seg_o.ready;
  assign emit     = out_free && busy_q;
  assign fin_emit = emit && phase_q && !rst_pend_q && (cnt_q == LastBit);
  assign load     = q_valid_i && (!busy_q || fin_emit);
  assign q_pop_o  = load;
  assign cur_bit  = bits_q[BitsPerPixel-1];

  always_comb begin
    seg_next = '0;
    if (rst_pend_q) begin
      seg_next.pin_level = 1'b0;
      seg_next.duration  = cfg_i.reset_low;
      seg_next.last      = 1'b0;
    end else if (!phase_q) begin
      seg_next.pin_level = 1'b1;
      seg_next.duration  = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
      seg_next.last      = 1'b0;
    end else begin
      seg_next.pin_level = 1'b0;
      seg_next.duration  = cur_bit ? cfg_i.one_low : cfg_i.zero_low;
      seg_next.last      = cnt_q == LastBit;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    rst_pend_d  = rst_pend_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    bits_d      = bits_q;
    out_valid_d = out_valid_q;
    seg_d       = seg_q;
    if (seg_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      seg_d       = seg_next;
      if (rst_pend_q) begin
        rst_pend_d = 1'b0;
      end else if (!phase_q) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        bits_d  = {bits_q[BitsPerPixel-2:0], 1'b0};
        cnt_d   = cnt_q + BitCntW'(1);
      end
    end
    if (fin_emit) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d     = 1'b1;
      bits_d     = q_word_i.bits;
      rst_pend_d = q_word_i.frame_start;
      phase_d    = 1'b0;
      cnt_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rst_pend_q  <= 1'b0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rst_pend_q  <= rst_pend_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    seg_q  <= seg_d;
  end

  assign seg_o.valid     = out_valid_q;
  assign seg_o.pin_level = seg_q.pin_level;
  assign seg_o.duration  = seg_q.duration;
  assign seg_o.last      = seg_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && seg_q.last) |-> !seg_q.pin_level)
    else $error("closing word of a pixel is not a low segment");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   busy_q |-> (cnt_q <= LastBit))
    else $error("bit counter ran past the pixel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && rst_pend_q) |-> (cnt_q == '0 && !phase_q))
    else $error("frame reset segment pending in the middle of a pixel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_pop_o |-> (!busy_q || fin_emit))
    else $error("next pixel taken while the current one is unfinished");

endmodule

/* rtl/rgb_led_pulse_width_encoder_unit.sv */
// The first segment word of a pixel passes the front register, the queue and the segment generator,
// which registers it for the output, when the queue and the segment generator are empty.
// Throughput: one segment word per cycle while the sink is ready, 48 words per pixel, 49 for the first
// of a frame, from the single segment generator; pixels queue up in the meantime.
// Reset clears the pipeline and the queue and returns all durations to their default values.
module rgb_led_pulse_width_encoder_unit
  import rgbpwe_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rgbpwe_pixel_if.sink        pix_i,
  rgbpwe_seg_if.source        seg_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TickW-1:0]    cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  logic  push, push_ready, q_valid, q_pop;
  word_t push_word, q_word;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ONE_HIGH:  cfg_d.one_high  = min_one(cfg_data_i);
        CFG_ONE_LOW:   cfg_d.one_low   = min_one(cfg_data_i);
        CFG_ZERO_HIGH: cfg_d.zero_high = min_one(cfg_data_i);
        CFG_ZERO_LOW:  cfg_d.zero_low  = min_one(cfg_data_i);
        CFG_RESET_LOW: cfg_d.reset_low = min_one(cfg_data_i);
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high  <= OneHighRst;
      cfg_q.one_low   <= OneLowRst;
      cfg_q.zero_high <= ZeroHighRst;
      cfg_q.zero_low  <= ZeroLowRst;
      cfg_q.reset_low <= ResetLowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rgbpwe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .push_o       (push),
    .push_word_o  (push_word),
    .push_ready_i (push_ready)
  );

  rgbpwe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_word_i  (push_word),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_word_o   (q_word),
    .pop_i        (q_pop)
  );

  rgbpwe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_word_i  (q_word),
    .q_pop_o   (q_pop),
    .seg_o     (seg_o)
  );

endmodule

/* sim/rgb_led_pulse_width_encoder_unit_test.sv */
module rgb_led_pulse_width_encoder_unit_test;
  import rgbpwe_pkg::*;

  localparam int unsigned NumCfgRegs = 5;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PixelsPerPhase = 25;
  localparam int unsigned NumPhases = 6;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [TickW-1:0] cfg_data_i;

  rgbpwe_pixel_if pix_bus ();
  rgbpwe_seg_if seg_bus ();

  rgb_led_pulse_width_encoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_bus.sink),
    .seg_o      (seg_bus.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [TickW-1:0] tick_reg [NumCfgRegs];
  pixel_t pixel_q[$];
  seg_t seg_expect_q[$];
  pixel_t pix_next;
  seg_t seg_want;
  int fail_cnt = 0;
  int src_idle_pct = 32;
  int sink_idle_pct = 55;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A register that holds zero stretches its segments to one tick.
  function automatic logic [TickW-1:0] tick_len(input cfg_idx_e r);
    return (tick_reg[r] == '0) ? TickW'(1) : tick_reg[r];
  endfunction

  function automatic void encode_pixel(input pixel_t px);
    logic [BitsPerPixel-1:0] bits;
    seg_t s;
    bits = {px.green, px.red, px.blue};
    if (px.frame_start) begin
      s.pin_level = 1'b0;
      s.duration = tick_len(CFG_RESET_LOW);
      s.last = 1'b0;
      seg_expect_q.push_back(s);
    end
    for (int b = BitsPerPixel - 1; b >= 0; b--) begin
      s.pin_level = 1'b1;
      s.duration = bits[b] ? tick_len(CFG_ONE_HIGH) : tick_len(CFG_ZERO_HIGH);
      s.last = 1'b0;
      seg_expect_q.push_back(s);
      s.pin_level = 1'b0;
      s.duration = bits[b] ? tick_len(CFG_ONE_LOW) : tick_len(CFG_ZERO_LOW);
      s.last = (b == 0);
      seg_expect_q.push_back(s);
    end
  endfunction

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic fs);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.frame_start = fs;
    pixel_q.push_back(px);
  endtask

  task automatic write_tick_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx < NumCfgRegs) begin
      tick_reg[idx] = val;
    end
  endtask

  // Every setting also carries one write to an unused index, which must change nothing.
  task automatic set_ticks(input logic [TickW-1:0] one_hi, input logic [TickW-1:0] one_lo,
                           input logic [TickW-1:0] zero_hi, input logic [TickW-1:0] zero_lo,
                           input logic [TickW-1:0] rst_lo);
    write_tick_reg(CFG_ONE_HIGH, one_hi);
    write_tick_reg(CFG_ONE_LOW, one_lo);
    write_tick_reg(CFG_ZERO_HIGH, zero_hi);
    write_tick_reg(CFG_ZERO_LOW, zero_lo);
    write_tick_reg(CFG_RESET_LOW, rst_lo);
    write_tick_reg(CfgIdxW'($urandom_range(NumCfgRegs, (1 << CfgIdxW) - 1)),
                   TickW'($urandom_range(0, 65535)));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (pixel_q.size() != 0 || pix_bus.valid || seg_expect_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [TickW-1:0] rand_ticks();
    return TickW'($urandom_range(1, 65535));
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_bus.valid <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        encode_pixel('{red: pix_bus.red, green: pix_bus.green, blue: pix_bus.blue,
                       frame_start: pix_bus.frame_start});
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          pix_next = pixel_q.pop_front();
          pix_bus.valid <= 1'b1;
          pix_bus.red <= pix_next.red;
          pix_bus.green <= pix_next.green;
          pix_bus.blue <= pix_next.blue;
          pix_bus.frame_start <= pix_next.frame_start;
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seg_bus.ready <= 1'b0;
    end else begin
      if (seg_bus.valid && seg_bus.ready) begin
        if (seg_expect_q.size() == 0) begin
          $error("unexpected segment: pin_level %0d duration %0d last %0d",
                 seg_bus.pin_level, seg_bus.duration, seg_bus.last);
          fail_cnt++;
        end else begin
          seg_want = seg_expect_q.pop_front();
          if (seg_bus.pin_level !== seg_want.pin_level) begin
            $error("pin_level: expected %0d, got %0d", seg_want.pin_level, seg_bus.pin_level);
            fail_cnt++;
          end
          if (seg_bus.duration !== seg_want.duration) begin
            $error("duration: expected %0d, got %0d", seg_want.duration, seg_bus.duration);
            fail_cnt++;
          end
          if (seg_bus.last !== seg_want.last) begin
            $error("last: expected %0d, got %0d", seg_want.last, seg_bus.last);
            fail_cnt++;
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        seg_bus.ready <= 1'b0;
      end else begin
        seg_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix_bus.valid && pix_bus.ready) || (seg_bus.valid && seg_bus.ready) ||
        (pixel_q.size() == 0 && !pix_bus.valid && seg_expect_q.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("rgb_led_pulse_width_encoder_unit_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    pix_bus.valid = 1'b0;
    pix_bus.red = '0;
    pix_bus.green = '0;
    pix_bus.blue = '0;
    pix_bus.frame_start = 1'b0;
    seg_bus.ready = 1'b0;
    tick_reg[CFG_ONE_HIGH] = OneHighRst;
    tick_reg[CFG_ONE_LOW] = OneLowRst;
    tick_reg[CFG_ZERO_HIGH] = ZeroHighRst;
    tick_reg[CFG_ZERO_LOW] = ZeroLowRst;
    tick_reg[CFG_RESET_LOW] = ResetLowRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The default durations are checked first, on hand-picked pixels.
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    add_pixel(8'h80, 8'h80, 8'h80, 1'b0);
    add_pixel(8'h01, 8'h01, 8'h01, 1'b1);
    add_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hff, 1'b0);
    add_pixel(8'haa, 8'h55, 8'haa, 1'b1);
    add_pixel(8'h55, 8'haa, 8'h55, 1'b0);
    add_pixel(8'h80, 8'h01, 8'h80, 1'b0);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          set_ticks(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        end
        1: begin
          set_ticks(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        end
        2: begin
          set_ticks(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        end
        3: begin
          set_ticks(16'hffff, 16'd1, 16'd1, 16'hffff, 16'd0);
        end
        default: begin
          set_ticks(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks());
        end
      endcase
      if (ph < 2) begin
        src_idle_pct = 32;
        sink_idle_pct = 55;
      end else if (ph < 4) begin
        src_idle_pct = 55;
        sink_idle_pct = 32;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      repeat (PixelsPerPhase) begin
        add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      // The output is blocked for a long stretch so that the pixel queue fills.
      if (ph == 4) begin
        hold_armed = 1'b1;
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("rgb_led_pulse_width_encoder_unit_test: PASS");
    end else begin
      $display("rgb_led_pulse_width_encoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule
